@@ hw/rtl/sbuc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbuc_pkg
// Shared types and constants of the sprite blitter: register map,
// configuration bundle and the command word between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package sbuc_pkg;

	localparam int unsigned DIM_W   = 11;
	localparam int unsigned ORG_W   = 16;
	localparam int unsigned COLOR_W = 16;
	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QPTR_W  = 2;
	localparam int unsigned QCNT_W  = 3;
	localparam int unsigned OUT_W   = 40;

	typedef enum logic [IDX_W-1:0] {
		REG_FB_WIDTH   = 3'd0,
		REG_FB_HEIGHT  = 3'd1,
		REG_TEX_WIDTH  = 3'd2,
		REG_TEX_HEIGHT = 3'd3,
		REG_ORIGIN_X   = 3'd4,
		REG_ORIGIN_Y   = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic        [DIM_W-1:0] fb_width;
		logic        [DIM_W-1:0] fb_height;
		logic        [DIM_W-1:0] tex_width;
		logic        [DIM_W-1:0] tex_height;
		logic signed [ORG_W-1:0] origin_x;
		logic signed [ORG_W-1:0] origin_y;
	} cfg_t;

	typedef struct packed {
		logic [DIM_W-1:0]   fx;
		logic [DIM_W-1:0]   fy;
		logic [COLOR_W-1:0] color;
		logic [3:0]         mask;
	} blit_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/sbuc_front.sv @@
// ----------------------------------------------------------------------------
// sbuc_front
// Texture walker: tracks the source column and row, places the cell and
// works out which of its up to four pixels land inside the framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sbuc_front import sbuc_pkg::*; #(
	parameter int unsigned MAX_DIM = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               s_valid,
	output logic                    s_ready,
	input  wire logic [COLOR_W-1:0] s_color,
	output logic                    q_push,
	output blit_cmd_t               q_cmd,
	input  wire logic               q_full
);

	localparam int unsigned CW = $clog2(MAX_DIM);
	localparam int unsigned DW = (CW + 2 > DIM_W + 1) ? CW + 2 : DIM_W + 1;
	localparam int unsigned PW = (CW + 3 > 18) ? CW + 3 : 18;

	logic [CW-1:0] col_q, row_q;
	logic [DW-1:0] ew, eh, tw, th;
	logic [DW-1:0] col_a, row_a, col_n, row_n, xoff, yoff;
	logic          sx, sy, empty_tex, accept;

	logic                 vld_s1;
	logic [PW-1:0]        bx_s1, by_s1;
	logic                 sx_s1, sy_s1;
	logic [COLOR_W-1:0]   color_s1;

	logic [PW-1:0]  fx0, fx1, fy0, fy1;
	logic [PW-1:0]  fbw_e, fbh_e;
	logic           okx0, okx1, oky0, oky1;
	logic [3:0]     mask;
	logic           advance;

	assign tw = DW'(cfg.tex_width);
	assign th = DW'(cfg.tex_height);
	assign ew = (tw > DW'(MAX_DIM)) ? DW'(MAX_DIM) : tw;
	assign eh = (th > DW'(MAX_DIM)) ? DW'(MAX_DIM) : th;
	assign sx = cfg.tex_width < cfg.fb_width;
	assign sy = cfg.tex_height < cfg.fb_height;
	assign empty_tex = (ew == '0) || (eh == '0);

	always_comb begin
		col_a = DW'(col_q);
		row_a = DW'(row_q);
		if (col_a >= ew) begin
			col_a = '0;
			row_a = row_a + DW'(1);
		end
		if (row_a >= eh) begin
			row_a = '0;
		end
		col_n = col_a + DW'(1);
		row_n = row_a;
		if (col_n >= ew) begin
			col_n = '0;
			row_n = row_a + DW'(1);
			if (row_n >= eh) begin
				row_n = '0;
			end
		end
		xoff = sx ? {col_a[DW-2:0], 1'b0} : col_a;
		yoff = sy ? {row_a[DW-2:0], 1'b0} : row_a;
	end

	assign fx0   = bx_s1;
	assign fx1   = bx_s1 + PW'(1);
	assign fy0   = by_s1;
	assign fy1   = by_s1 + PW'(1);
	assign fbw_e = PW'(cfg.fb_width);
	assign fbh_e = PW'(cfg.fb_height);
	assign okx0  = !fx0[PW-1] && (fx0 < fbw_e);
	assign okx1  = sx_s1 && !fx1[PW-1] && (fx1 < fbw_e);
	assign oky0  = !fy0[PW-1] && (fy0 < fbh_e);
	assign oky1  = sy_s1 && !fy1[PW-1] && (fy1 < fbh_e);
	assign mask  = {oky1 & okx1, oky1 & okx0, oky0 & okx1, oky0 & okx0};

	assign advance = !vld_s1 || (mask == 4'b0000) || !q_full;
	assign s_ready = advance;
	assign accept  = s_valid && s_ready;
	assign q_push  = vld_s1 && (mask != 4'b0000) && !q_full;

	always_comb begin
		q_cmd.fx    = fx0[DIM_W-1:0];
		q_cmd.fy    = fy0[DIM_W-1:0];
		q_cmd.color = color_s1;
		q_cmd.mask  = mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (advance) begin
				vld_s1 <= accept && !empty_tex;
			end
			if (accept && !empty_tex) begin
				col_q <= col_n[CW-1:0];
				row_q <= row_n[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !empty_tex) begin
			bx_s1    <= {{(PW-ORG_W){cfg.origin_x[ORG_W-1]}}, cfg.origin_x} + PW'(xoff);
			by_s1    <= {{(PW-ORG_W){cfg.origin_y[ORG_W-1]}}, cfg.origin_y} + PW'(yoff);
			sx_s1    <= sx;
			sy_s1    <= sy;
			color_s1 <= s_color;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (mask[0] || mask[1] || mask[2] || mask[3]))
		else $error("push of a fully clipped cell");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !empty_tex) |=> vld_s1)
		else $error("accepted pixel lost before the clip stage");
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(bx_s1) && $stable(by_s1))
		else $error("stalled cell changed");

endmodule

`default_nettype wire

@@ hw/rtl/sbuc_fifo.sv @@
// ----------------------------------------------------------------------------
// sbuc_fifo
// Short command queue between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module sbuc_fifo import sbuc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire blit_cmd_t push_cmd,
	output logic           full,
	input  wire logic      pop,
	output blit_cmd_t      head,
	output logic           nonempty
);

	blit_cmd_t         mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = cnt_q == QCNT_W'(QDEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> nonempty)
		else $error("queue underflow");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

@@ hw/rtl/sbuc_back.sv @@
// ----------------------------------------------------------------------------
// sbuc_back
// Write issuer: walks the visible pixels of each cell, one per cycle unless
// stalled, and forms the linear framebuffer address in two registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sbuc_back import sbuc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [DIM_W-1:0] fb_width,
	input  wire blit_cmd_t        q_head,
	input  wire logic             q_nonempty,
	output logic                  q_pop,
	output logic                  m_valid,
	input  wire logic             m_ready,
	output logic [ADDR_W-1:0]     m_addr,
	output logic [COLOR_W-1:0]    m_color,
	output logic                  m_last
);

	localparam int unsigned PROD_W = 2 * DIM_W;

	blit_cmd_t          cur_q;
	logic               cur_vld_q;
	logic [3:0]         rem_q;
	logic [1:0]         sel;
	logic [3:0]         rem_left;
	logic               last;
	logic [DIM_W-1:0]   fx, fy;
	logic               en, load;

	logic               vld_s1, last_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [DIM_W-1:0]   fx_s1;
	logic [COLOR_W-1:0] color_s1;

	logic               vld_s2, last_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic [COLOR_W-1:0] color_s2;

	always_comb begin
		if (rem_q[0]) begin
			sel = 2'd0;
		end else if (rem_q[1]) begin
			sel = 2'd1;
		end else if (rem_q[2]) begin
			sel = 2'd2;
		end else begin
			sel = 2'd3;
		end
		rem_left = rem_q & ~(4'b0001 << sel);
		last     = rem_left == 4'b0000;
		fx       = cur_q.fx + DIM_W'(sel[0]);
		fy       = cur_q.fy + DIM_W'(sel[1]);
	end

	assign en    = !vld_s2 || m_ready;
	assign load  = en && (!cur_vld_q || last);
	assign q_pop = load && q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			rem_q     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else if (en) begin
			vld_s1 <= cur_vld_q;
			vld_s2 <= vld_s1;
			if (load) begin
				cur_vld_q <= q_nonempty;
				rem_q     <= q_nonempty ? q_head.mask : 4'b0000;
			end else begin
				rem_q <= rem_left;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (q_pop) begin
				cur_q <= q_head;
			end
			prod_s1  <= PROD_W'(fy) * PROD_W'(fb_width);
			fx_s1    <= fx;
			color_s1 <= cur_q.color;
			last_s1  <= last;
			addr_s2  <= ADDR_W'(prod_s1 + PROD_W'(fx_s1));
			color_s2 <= color_s1;
			last_s2  <= last_s1;
		end
	end

	assign m_valid = vld_s2;
	assign m_addr  = addr_s2;
	assign m_color = color_s2;
	assign m_last  = last_s2;

	assert property (@(posedge clk) disable iff (!arst_n) cur_vld_q |-> rem_q != 4'b0000)
		else $error("active cell with no pixels left");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> en)
		else $error("queue popped during output stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q && !last && en |=> cur_vld_q)
		else $error("cell dropped before its last write");

endmodule

`default_nettype wire

@@ hw/rtl/sprite_blit_upscale_clip.sv @@
// ----------------------------------------------------------------------------
// sprite_blit_upscale_clip
// Turns row-major texture pixels into clipped, optionally 2x upscaled
// framebuffer writes (address, color).
// A pixel passes the front clip stage, the command queue, the cell register and the address stages.
// Throughput: one write beat per cycle while m_axis_tready is high; a pixel yields up to four
// writes, and new pixels are taken while the command queue has room.
// Reset: registers return to their defaults and the source counters to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blit_upscale_clip import sbuc_pkg::*; #(
	parameter int unsigned MAX_DIM = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [ORG_W-1:0]   cfg_data,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [COLOR_W-1:0] s_axis_tdata,   // [15:0] pixel_color
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [OUT_W-1:0]        m_axis_tdata,   // [19:0] write_address, [35:20] write_color
	output logic                    m_axis_tlast
);

	cfg_t              cfg_q;
	logic              q_push, q_full, q_pop, q_nonempty;
	blit_cmd_t         q_in, q_head;
	logic [ADDR_W-1:0] addr;
	logic [COLOR_W-1:0] color;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_width   <= DIM_W'(172);
			cfg_q.fb_height  <= DIM_W'(320);
			cfg_q.tex_width  <= '0;
			cfg_q.tex_height <= '0;
			cfg_q.origin_x   <= '0;
			cfg_q.origin_y   <= '0;
		end else if (cfg_valid) begin
			case (reg_index_t'(cfg_index))
				REG_FB_WIDTH:   cfg_q.fb_width   <= cfg_data[DIM_W-1:0];
				REG_FB_HEIGHT:  cfg_q.fb_height  <= cfg_data[DIM_W-1:0];
				REG_TEX_WIDTH:  cfg_q.tex_width  <= cfg_data[DIM_W-1:0];
				REG_TEX_HEIGHT: cfg_q.tex_height <= cfg_data[DIM_W-1:0];
				REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data;
				REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data;
				default: ;
			endcase
		end
	end

	sbuc_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_color (s_axis_tdata),
		.q_push  (q_push),
		.q_cmd   (q_in),
		.q_full  (q_full)
	);

	sbuc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.nonempty (q_nonempty)
	);

	sbuc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fb_width   (cfg_q.fb_width),
		.q_head     (q_head),
		.q_nonempty (q_nonempty),
		.q_pop      (q_pop),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_addr     (addr),
		.m_color    (color),
		.m_last     (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_W-ADDR_W-COLOR_W){1'b0}}, color, addr};

endmodule

`default_nettype wire
